// ===== hw/rtl/tmh_pkg.sv =====
// shared types, constants and codes of the timer min-heap scheduler
package tmh_pkg;

   localparam int HEAP_DEPTH = 32;
   localparam int TIME_BITS  = 48;
   localparam int NUM_TAGS   = 32;
   localparam int TAG_BITS   = $clog2(NUM_TAGS);
   localparam int IDX_BITS   = $clog2(HEAP_DEPTH);
   localparam int SIZE_BITS  = $clog2(HEAP_DEPTH + 1);

   // fixed widths of the channel fields
   localparam int OP_BITS       = 3;
   localparam int STATUS_BITS   = 2;
   localparam int POS_BITS      = 5;
   localparam int OUT_TIME_BITS = 48;
   localparam int CNT_BITS      = 6;

   typedef enum logic [OP_BITS-1:0] {
      OP_INSERT  = 3'd0,
      OP_REMOVE  = 3'd1,
      OP_RESCHED = 3'd2,
      OP_FIRE    = 3'd3,
      OP_TIMEOUT = 3'd4,
      OP_CLEAR   = 3'd5
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_TAG   = 2'd3
   } status_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] expiry;
      logic [TAG_BITS-1:0]  tag;
   } entry_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_RM_OLD,
      S_RS_OLD,
      S_LAST,
      S_UP_RD,
      S_UP_CMP,
      S_DN_CHK,
      S_DN_L,
      S_DN_R,
      S_DN_CMP,
      S_PUT,
      S_FIRE_CHK,
      S_FIRE_CMP,
      S_FIRE_END,
      S_TO_CMP,
      S_RESULT
   } state_type;

endpackage

// ===== hw/rtl/tmh_if.sv =====
// request and response channel interfaces of the timer min-heap scheduler
interface tmh_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] operation;
   logic [4:0] job_tag;
   logic [47:0] expiry_time;
   logic [47:0] now_time;

   modport source (output valid, output operation, output job_tag, output expiry_time,
                   output now_time, input ready);
   modport sink   (input valid, input operation, input job_tag, input expiry_time,
                   input now_time, output ready);
endinterface

interface tmh_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [4:0]  fired_tag;
   logic        fired_valid;
   logic [4:0]  heap_position;
   logic [47:0] time_left;
   logic [5:0]  fire_count;
   logic        last;

   modport source (output valid, output status, output fired_tag, output fired_valid,
                   output heap_position, output time_left, output fire_count,
                   output last, input ready);
   modport sink   (input valid, input status, input fired_tag, input fired_valid,
                   input heap_position, input time_left, input fire_count,
                   input last, output ready);
endinterface

// ===== hw/rtl/tmh_ram.sv =====
// generic single write port ram with registered read
module tmh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, held while idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tmh_cmp.sv =====
// shared expiry compare and subtract unit
module tmh_cmp (
   input  logic [tmh_pkg::TIME_BITS-1:0] a,
   input  logic [tmh_pkg::TIME_BITS-1:0] b,
   output logic                          lt,
   output logic [tmh_pkg::TIME_BITS-1:0] diff
);
   import tmh_pkg::*;

   // a below b, and distance from a up to b
   assign lt   = (a < b);
   assign diff = b - a;

endmodule

// ===== hw/rtl/timer_min_heap_scheduler.sv =====
// top level of the timer min-heap scheduler
//
// Usage: one operation enters per transfer on req_chan (insert, remove,
// reschedule, fire, timeout query, clear all); results leave on rsp_chan,
// the final one of each operation marked by last. Fire gives one result
// per due job, earliest first, or a single empty result when none is due.
// The heap lives in one ram with a registered read; a tag-to-position
// table with a scheduled flag per tag sits in flip-flops. A sequencer
// steps one shared compare unit through the sift loop, one ram read and
// at most one ram write per cycle.
// Insert sifts the new entry up one heap level per step; remove and
// reschedule sift the moved entry up or down, and fire pops each due
// root and sifts the tail entry down while entries remain.
// req_chan is ready only between operations.
// Reset (synchronous) empties the heap and marks every tag unscheduled.
// A stalled receiver holds the output register; the sequencer waits on
// it before writing each further result, and no result is lost.
module timer_min_heap_scheduler (
   input  logic         clock,
   input  logic         reset,
   tmh_req_if.sink      req_chan,
   tmh_rsp_if.source    rsp_chan
);
   import tmh_pkg::*;

   state_type                state_ff, state_in;
   op_type                   op_ff, op_in;
   logic [TAG_BITS-1:0]      tag_ff, tag_in;
   logic [TIME_BITS-1:0]     now_ff, now_in;
   logic [TIME_BITS-1:0]     cur_exp_ff, cur_exp_in;
   logic [TAG_BITS-1:0]      cur_tag_ff, cur_tag_in;
   logic [TIME_BITS-1:0]     old_exp_ff, old_exp_in;
   logic [TIME_BITS-1:0]     y_exp_ff, y_exp_in;
   logic [TAG_BITS-1:0]      y_tag_ff, y_tag_in;
   logic [IDX_BITS-1:0]      y_idx_ff, y_idx_in;
   logic [IDX_BITS-1:0]      idx_ff, idx_in;
   logic [SIZE_BITS-1:0]     size_ff, size_in;
   logic [SIZE_BITS-1:0]     cnt_ff, cnt_in;
   logic [TAG_BITS-1:0]      pend_tag_ff, pend_tag_in;
   status_type               res_status_ff, res_status_in;
   logic [IDX_BITS-1:0]      res_pos_ff, res_pos_in;
   logic [TIME_BITS-1:0]     res_time_ff, res_time_in;
   logic [NUM_TAGS-1:0]      sched_ff, sched_in;
   logic [IDX_BITS-1:0]      tpos_ff [NUM_TAGS];
   logic                     tpos_we;
   logic [TAG_BITS-1:0]      tpos_wtag;
   logic [IDX_BITS-1:0]      tpos_wval;

   // output register
   logic                     out_valid_ff;
   status_type               out_status_ff;
   logic [TAG_BITS-1:0]      out_tag_ff;
   logic                     out_fvalid_ff;
   logic [IDX_BITS-1:0]      out_pos_ff;
   logic [TIME_BITS-1:0]     out_time_ff;
   logic [SIZE_BITS-1:0]     out_cnt_ff;
   logic                     out_last_ff;
   logic                     emit;
   status_type               e_status;
   logic [TAG_BITS-1:0]      e_tag;
   logic                     e_fvalid;
   logic [IDX_BITS-1:0]      e_pos;
   logic [TIME_BITS-1:0]     e_time;
   logic [SIZE_BITS-1:0]     e_cnt;
   logic                     e_last;

   // ram ports
   logic                     wr_en, rd_en;
   logic [IDX_BITS-1:0]      wr_addr, rd_addr;
   entry_type                wr_data, rd_data;

   // compare unit
   logic [TIME_BITS-1:0]     cmp_a, cmp_b, cmp_diff;
   logic                     cmp_lt;

   // derived conditions
   logic                     accept, out_free, sched_hit, full, at_leaf, r_ok;
   logic [IDX_BITS-1:0]      tpos_hit, parent_idx, l_idx, r_idx;
   logic [SIZE_BITS-1:0]     size_m1, r_sz;

   tmh_ram #(.WIDTH($bits(entry_type)), .DEPTH(HEAP_DEPTH)) u_heap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tmh_cmp u_cmp (
      .a    (cmp_a),
      .b    (cmp_b),
      .lt   (cmp_lt),
      .diff (cmp_diff)
   );

   assign accept     = req_chan.valid && req_chan.ready;
   assign out_free   = !out_valid_ff || rsp_chan.ready;
   assign tpos_hit   = tpos_ff[tag_ff];
   assign sched_hit  = sched_ff[tag_ff] && (SIZE_BITS'(tpos_hit) < size_ff);
   assign full       = (size_ff == SIZE_BITS'(HEAP_DEPTH));
   assign size_m1    = size_ff - SIZE_BITS'(1);
   assign parent_idx = (idx_ff - IDX_BITS'(1)) >> 1;
   assign l_idx      = IDX_BITS'({idx_ff, 1'b1});
   assign r_sz       = SIZE_BITS'(l_idx) + SIZE_BITS'(1);
   assign r_idx      = IDX_BITS'(r_sz);
   assign r_ok       = (r_sz < size_ff);
   assign at_leaf    = (SIZE_BITS'(idx_ff) >= (size_ff >> 1));

   // compare operand selection
   always_comb begin
      cmp_a = cur_exp_ff;
      cmp_b = rd_data.expiry;
      case (state_ff)
         S_LAST: begin
            cmp_a = rd_data.expiry;
            cmp_b = old_exp_ff;
         end
         S_DN_R: begin
            cmp_a = rd_data.expiry;
            cmp_b = y_exp_ff;
         end
         S_DN_CMP: begin
            cmp_a = cur_exp_ff;
            cmp_b = y_exp_ff;
         end
         S_FIRE_CMP, S_TO_CMP: begin
            cmp_a = now_ff;
            cmp_b = rd_data.expiry;
         end
         default: begin
            cmp_a = cur_exp_ff;
            cmp_b = rd_data.expiry;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (req_chan.valid) state_in = S_DECODE;
         S_DECODE: begin
            unique case (op_ff)
               OP_INSERT:  state_in = (sched_hit || full) ? S_RESULT : S_UP_RD;
               OP_REMOVE: begin
                  if (!sched_hit || size_m1 == '0 || SIZE_BITS'(tpos_hit) == size_m1) begin
                     state_in = S_RESULT;
                  end else begin
                     state_in = S_RM_OLD;
                  end
               end
               OP_RESCHED: state_in = sched_hit ? S_RS_OLD : S_RESULT;
               OP_FIRE:    state_in = S_FIRE_CHK;
               OP_TIMEOUT: state_in = (size_ff == '0) ? S_RESULT : S_TO_CMP;
               default:    state_in = S_RESULT;
            endcase
         end
         S_RM_OLD:   state_in = S_LAST;
         S_RS_OLD:   state_in = cmp_lt ? S_UP_RD : S_DN_CHK;
         S_LAST:     state_in = cmp_lt ? S_UP_RD : S_DN_CHK;
         S_UP_RD:    state_in = (idx_ff == '0) ? S_PUT : S_UP_CMP;
         S_UP_CMP:   state_in = cmp_lt ? S_UP_RD : S_PUT;
         S_DN_CHK:   state_in = at_leaf ? S_PUT : S_DN_L;
         S_DN_L:     state_in = r_ok ? S_DN_R : S_DN_CMP;
         S_DN_R:     state_in = S_DN_CMP;
         S_DN_CMP:   state_in = cmp_lt ? S_PUT : S_DN_CHK;
         S_PUT:      state_in = (op_ff == OP_FIRE) ? S_FIRE_CHK : S_RESULT;
         S_FIRE_CHK: state_in = (size_ff == '0) ? S_FIRE_END : S_FIRE_CMP;
         S_FIRE_CMP: begin
            if (cmp_lt) begin
               state_in = S_FIRE_END;
            end else if (cnt_ff != '0 && !out_free) begin
               state_in = S_FIRE_CMP;
            end else if (size_m1 != '0) begin
               state_in = S_LAST;
            end else begin
               state_in = S_FIRE_CHK;
            end
         end
         S_FIRE_END: if (out_free) state_in = S_IDLE;
         S_TO_CMP:   state_in = S_RESULT;
         S_RESULT:   if (out_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath, ram and result controls
   always_comb begin
      op_in         = op_ff;
      tag_in        = tag_ff;
      now_in        = now_ff;
      cur_exp_in    = cur_exp_ff;
      cur_tag_in    = cur_tag_ff;
      old_exp_in    = old_exp_ff;
      y_exp_in      = y_exp_ff;
      y_tag_in      = y_tag_ff;
      y_idx_in      = y_idx_ff;
      idx_in        = idx_ff;
      size_in       = size_ff;
      cnt_in        = cnt_ff;
      pend_tag_in   = pend_tag_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_time_in   = res_time_ff;
      sched_in      = sched_ff;
      tpos_we       = 1'b0;
      tpos_wtag     = cur_tag_ff;
      tpos_wval     = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = '{expiry: cur_exp_ff, tag: cur_tag_ff};
      rd_en         = 1'b0;
      rd_addr       = '0;
      emit          = 1'b0;
      e_status      = ST_OK;
      e_tag         = '0;
      e_fvalid      = 1'b0;
      e_pos         = '0;
      e_time        = '0;
      e_cnt         = '0;
      e_last        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in         = op_type'(req_chan.operation);
               tag_in        = req_chan.job_tag;
               cur_tag_in    = req_chan.job_tag;
               cur_exp_in    = TIME_BITS'(req_chan.expiry_time);
               now_in        = TIME_BITS'(req_chan.now_time);
               cnt_in        = '0;
               res_status_in = ST_OK;
               res_pos_in    = '0;
               res_time_in   = '0;
            end
         end
         S_DECODE: begin
            unique case (op_ff)
               OP_INSERT: begin
                  if (sched_hit) begin
                     res_status_in = ST_TAG;
                  end else if (full) begin
                     res_status_in = ST_FULL;
                  end else begin
                     idx_in           = IDX_BITS'(size_ff);
                     size_in          = size_ff + SIZE_BITS'(1);
                     sched_in[tag_ff] = 1'b1;
                  end
               end
               OP_REMOVE: begin
                  if (!sched_hit) begin
                     res_status_in = ST_TAG;
                  end else begin
                     sched_in[tag_ff] = 1'b0;
                     size_in          = size_m1;
                     idx_in           = tpos_hit;
                     rd_en            = 1'b1;
                     rd_addr          = tpos_hit;
                  end
               end
               OP_RESCHED: begin
                  if (!sched_hit) begin
                     res_status_in = ST_TAG;
                  end else begin
                     idx_in  = tpos_hit;
                     rd_en   = 1'b1;
                     rd_addr = tpos_hit;
                  end
               end
               OP_TIMEOUT: begin
                  if (size_ff == '0) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = '0;
                  end
               end
               OP_CLEAR: begin
                  sched_in = '0;
                  size_in  = '0;
               end
               default: begin
                  res_status_in = ST_OK;
               end
            endcase
         end
         // old entry read back, fetch the tail entry
         S_RM_OLD: begin
            old_exp_in = rd_data.expiry;
            rd_en      = 1'b1;
            rd_addr    = IDX_BITS'(size_ff);
         end
         S_LAST: begin
            cur_exp_in = rd_data.expiry;
            cur_tag_in = rd_data.tag;
         end
         S_UP_RD: begin
            if (idx_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = parent_idx;
            end
         end
         // parent moves down one level
         S_UP_CMP: begin
            if (cmp_lt) begin
               wr_en     = 1'b1;
               wr_addr   = idx_ff;
               wr_data   = rd_data;
               tpos_we   = 1'b1;
               tpos_wtag = rd_data.tag;
               tpos_wval = idx_ff;
               idx_in    = parent_idx;
            end
         end
         S_DN_CHK: begin
            if (!at_leaf) begin
               rd_en   = 1'b1;
               rd_addr = l_idx;
            end
         end
         S_DN_L: begin
            y_exp_in = rd_data.expiry;
            y_tag_in = rd_data.tag;
            y_idx_in = l_idx;
            if (r_ok) begin
               rd_en   = 1'b1;
               rd_addr = r_idx;
            end
         end
         S_DN_R: begin
            if (cmp_lt) begin
               y_exp_in = rd_data.expiry;
               y_tag_in = rd_data.tag;
               y_idx_in = r_idx;
            end
         end
         // smaller child moves up one level
         S_DN_CMP: begin
            if (!cmp_lt) begin
               wr_en     = 1'b1;
               wr_addr   = idx_ff;
               wr_data   = '{expiry: y_exp_ff, tag: y_tag_ff};
               tpos_we   = 1'b1;
               tpos_wtag = y_tag_ff;
               tpos_wval = idx_ff;
               idx_in    = y_idx_ff;
            end
         end
         S_PUT: begin
            wr_en     = 1'b1;
            wr_addr   = idx_ff;
            wr_data   = '{expiry: cur_exp_ff, tag: cur_tag_ff};
            tpos_we   = 1'b1;
            tpos_wtag = cur_tag_ff;
            tpos_wval = idx_ff;
            if (op_ff == OP_INSERT || op_ff == OP_RESCHED) begin
               res_pos_in = idx_ff;
            end
         end
         S_FIRE_CHK: begin
            if (size_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = '0;
            end
         end
         // root due: flush the pending result, pop the root
         S_FIRE_CMP: begin
            if (!cmp_lt && (cnt_ff == '0 || out_free)) begin
               if (cnt_ff != '0) begin
                  emit     = 1'b1;
                  e_tag    = pend_tag_ff;
                  e_fvalid = 1'b1;
                  e_cnt    = cnt_ff;
               end
               pend_tag_in            = rd_data.tag;
               cnt_in                 = cnt_ff + SIZE_BITS'(1);
               sched_in[rd_data.tag]  = 1'b0;
               size_in                = size_m1;
               old_exp_in             = rd_data.expiry;
               idx_in                 = '0;
               if (size_m1 != '0) begin
                  rd_en   = 1'b1;
                  rd_addr = IDX_BITS'(size_m1);
               end
            end
         end
         S_FIRE_END: begin
            if (out_free) begin
               emit   = 1'b1;
               e_last = 1'b1;
               if (cnt_ff != '0) begin
                  e_tag    = pend_tag_ff;
                  e_fvalid = 1'b1;
                  e_cnt    = cnt_ff;
               end
            end
         end
         S_TO_CMP: begin
            res_time_in = cmp_lt ? cmp_diff : '0;
         end
         S_RESULT: begin
            if (out_free) begin
               emit     = 1'b1;
               e_status = res_status_ff;
               e_pos    = res_pos_ff;
               e_time   = res_time_ff;
               e_last   = 1'b1;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         size_ff      <= '0;
         sched_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
         sched_ff <= sched_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      tag_ff        <= tag_in;
      now_ff        <= now_in;
      cur_exp_ff    <= cur_exp_in;
      cur_tag_ff    <= cur_tag_in;
      old_exp_ff    <= old_exp_in;
      y_exp_ff      <= y_exp_in;
      y_tag_ff      <= y_tag_in;
      y_idx_ff      <= y_idx_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      pend_tag_ff   <= pend_tag_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_time_ff   <= res_time_in;
      if (tpos_we) begin
         tpos_ff[tpos_wtag] <= tpos_wval;
      end
      if (emit) begin
         out_status_ff <= e_status;
         out_tag_ff    <= e_tag;
         out_fvalid_ff <= e_fvalid;
         out_pos_ff    <= e_pos;
         out_time_ff   <= e_time;
         out_cnt_ff    <= e_cnt;
         out_last_ff   <= e_last;
      end
   end

   // ports
   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.status        = out_status_ff;
   assign rsp_chan.fired_tag     = out_tag_ff;
   assign rsp_chan.fired_valid   = out_fvalid_ff;
   assign rsp_chan.heap_position = POS_BITS'(out_pos_ff);
   assign rsp_chan.time_left     = OUT_TIME_BITS'(out_time_ff);
   assign rsp_chan.fire_count    = CNT_BITS'(out_cnt_ff);
   assign rsp_chan.last          = out_last_ff;

endmodule
